// ===== design/swr_pkg.sv =====
// Package for the single-wire sensor frame receiver.
// Holds the word types, configuration struct, codes and sizing constants.
// No dependencies; every other design file uses it by scoped names.
`default_nettype none

package swr_pkg;

  // Frame and edge sizing.
  localparam int MAX_EDGES   = 85;
  localparam int FRAME_BITS  = 40;
  localparam int FRAME_BYTES = FRAME_BITS / 8;
  localparam int EDGE_W      = 7;
  localparam int BITCNT_W    = 6;
  localparam int RUN_W       = 8;
  localparam int COUNT_W     = 16;

  // The first transition after which high runs carry data.
  localparam logic [EDGE_W-1:0]  FIRST_DATA_EDGE = EDGE_W'(4);
  localparam logic [RUN_W-1:0]   RUN_MAX         = '1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LOW  = 2'd0,
    CFG_START_HIGH = 2'd1,
    CFG_ONE_THRESH = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  start_high_ticks;
    logic [7:0]  one_threshold;
    logic [7:0]  timeout_ticks;
  } cfg_t;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_RECV = 4'b1000
  } phase_t;

  typedef struct packed {
    logic action;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic                drive_enable;
    logic                drive_level;
    logic                busy_res;
    logic                done_res;
    logic [1:0]          status;
    logic [7:0]          humidity_int;
    logic [7:0]          humidity_frac;
    logic [7:0]          temp_int;
    logic [7:0]          temp_frac;
    logic [BITCNT_W-1:0] bits_received;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/swr_if.sv =====
// Valid/ready word channel interfaces for the input and result sides.
// Depends on swr_pkg for the word types.
`default_nettype none

interface swr_in_if;
  logic              valid;
  logic              ready;
  swr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swr_out_if;
  logic               valid;
  logic               ready;
  swr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/single_wire_sensor_frame_receiver.sv =====
// Host-side receiver for a single-wire humidity and temperature sensor. Each input
// word is either a start command or one microsecond tick carrying the sampled
// data line level; every input word yields exactly one result word that tells
// how to drive the line during that tick (drive_enable, drive_level), whether a
// read is busy or has just finished, the four data bytes, the number of decoded
// bits and a status (ok, too few bits, checksum mismatch). A start drives the
// line low for start_low_ticks ticks, then high for start_high_ticks ticks, and
// then releases it; from the fifth line transition on, each high pulse longer
// than one_threshold ticks decodes as a 1 bit. A read ends after timeout_ticks
// ticks without a transition or after 85 transitions. Throughput is one word per
// clock cycle while the result side is ready: the input register feeds a single
// pass of counting and shifting logic into the result register, so a word's
// result is written to the result register when the word leaves the input
// register, and it can be taken from there when the result side is ready.
// A stalled result word holds in the result register while the input register
// still takes one more word.
// Configuration writes are meant to happen only while no read is in progress.
// Depends on swr_pkg, swr_if, swr_cfg and swr_core.
`default_nettype none

module single_wire_sensor_frame_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  swr_in_if.sink                              in_ch,
  swr_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  swr_pkg::cfg_t      cfg;
  swr_pkg::in_item_t  in_word_r;
  swr_pkg::out_item_t result;
  swr_pkg::out_item_t out_word_r;
  logic               in_v_r;
  logic               out_v_r;
  logic               advance;

  // The held input word moves on whenever the result register is free or drains.
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_word_r;

  swr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_word_r),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r <= in_ch.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== design/swr_cfg.sv =====
// Configuration register file: four timing registers written by index.
// Depends on swr_pkg for the index codes and the configuration struct.
`default_nettype none

module swr_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output swr_pkg::cfg_t                       cfg
);

  swr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks  <= 16'd18000;
      cfg_r.start_high_ticks <= 8'd40;
      cfg_r.one_threshold    <= 8'd16;
      cfg_r.timeout_ticks    <= 8'd255;
    end else if (cfg_we) begin
      unique case (swr_pkg::cfg_idx_t'(cfg_index))
        swr_pkg::CFG_START_LOW:  cfg_r.start_low_ticks  <= cfg_wdata;
        swr_pkg::CFG_START_HIGH: cfg_r.start_high_ticks <= cfg_wdata[7:0];
        swr_pkg::CFG_ONE_THRESH: cfg_r.one_threshold    <= cfg_wdata[7:0];
        swr_pkg::CFG_TIMEOUT:    cfg_r.timeout_ticks    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/swr_core.sv =====
// Read sequencer: phase, run and edge counters, bit decoding and frame store.
// Computes one result word per step from the registered input word.
// Depends on swr_pkg.
`default_nettype none

module swr_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire swr_pkg::in_item_t  item,
  input  wire swr_pkg::cfg_t      cfg,
  output swr_pkg::out_item_t      result
);

  localparam int FB = swr_pkg::FRAME_BITS;
  localparam int FBYTES = swr_pkg::FRAME_BYTES;

  swr_pkg::phase_t                     phase_r, phase_nxt;
  logic [swr_pkg::COUNT_W-1:0]         count_r, count_nxt;
  logic                                last_r, last_nxt;
  logic [swr_pkg::RUN_W-1:0]           run_r, run_nxt;
  logic [swr_pkg::EDGE_W-1:0]          edge_r, edge_nxt;
  logic [swr_pkg::BITCNT_W-1:0]        bits_r, bits_nxt;
  logic [FB-1:0]                       frame_r, frame_nxt;

  logic       den, dlv, done, bit_val;
  logic [7:0] sum;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    run_nxt   = run_r;
    edge_nxt  = edge_r;
    bits_nxt  = bits_r;
    frame_nxt = frame_r;
    den       = 1'b0;
    dlv       = 1'b0;
    done      = 1'b0;
    bit_val   = run_r > cfg.one_threshold;

    if (item.action) begin
      phase_nxt = swr_pkg::PH_LOW;
      count_nxt = '0;
      last_nxt  = 1'b1;
      run_nxt   = '0;
      edge_nxt  = '0;
      bits_nxt  = '0;
      frame_nxt = '0;
      den       = 1'b1;
    end else begin
      unique case (phase_r)
        swr_pkg::PH_LOW: begin
          den       = 1'b1;
          count_nxt = count_r + 1'b1;
          if (count_nxt >= cfg.start_low_ticks) begin
            phase_nxt = swr_pkg::PH_HIGH;
            count_nxt = '0;
          end
        end
        swr_pkg::PH_HIGH: begin
          den       = 1'b1;
          dlv       = 1'b1;
          count_nxt = count_r + 1'b1;
          if (count_nxt >= {8'd0, cfg.start_high_ticks}) begin
            phase_nxt = swr_pkg::PH_RECV;
            count_nxt = '0;
          end
        end
        swr_pkg::PH_RECV: begin
          if (item.line_level == last_r) begin
            if (run_r != swr_pkg::RUN_MAX) begin
              run_nxt = run_r + 1'b1;
            end
            if (run_nxt >= cfg.timeout_ticks) begin
              phase_nxt = swr_pkg::PH_IDLE;
              done      = 1'b1;
            end
          end else begin
            // Only high runs after the sensor's response pulses carry data.
            if (edge_r >= swr_pkg::FIRST_DATA_EDGE && !edge_r[0] &&
                bits_r < swr_pkg::BITCNT_W'(FB)) begin
              for (int k = 0; k < FBYTES; k++) begin
                if (bits_r[swr_pkg::BITCNT_W-1:3] == (swr_pkg::BITCNT_W-3)'(k)) begin
                  frame_nxt[8*k +: 8] = {frame_r[8*k +: 7], bit_val};
                end
              end
              bits_nxt = bits_r + 1'b1;
            end
            edge_nxt = edge_r + 1'b1;
            last_nxt = item.line_level;
            run_nxt  = '0;
            if (edge_nxt >= swr_pkg::EDGE_W'(swr_pkg::MAX_EDGES)) begin
              phase_nxt = swr_pkg::PH_IDLE;
              done      = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sum = frame_nxt[7:0] + frame_nxt[15:8] + frame_nxt[23:16] + frame_nxt[31:24];

  always_comb begin
    result.drive_enable  = den;
    result.drive_level   = dlv;
    result.busy_res      = phase_nxt != swr_pkg::PH_IDLE;
    result.done_res      = done;
    result.humidity_int  = frame_nxt[7:0];
    result.humidity_frac = frame_nxt[15:8];
    result.temp_int      = frame_nxt[23:16];
    result.temp_frac     = frame_nxt[31:24];
    result.bits_received = bits_nxt;
    if (bits_nxt < swr_pkg::BITCNT_W'(FB)) begin
      result.status = swr_pkg::ST_SHORT;
    end else if (frame_nxt[39:32] != sum) begin
      result.status = swr_pkg::ST_CHECKSUM;
    end else begin
      result.status = swr_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swr_pkg::PH_IDLE;
      count_r <= '0;
      last_r  <= 1'b1;
      run_r   <= '0;
      edge_r  <= '0;
      bits_r  <= '0;
      frame_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      run_r   <= run_nxt;
      edge_r  <= edge_nxt;
      bits_r  <= bits_nxt;
      frame_r <= frame_nxt;
    end
  end

endmodule

`default_nettype wire
